// ===== design/mesp_pkg.sv =====
// Shared types and constants for the MIDI event stream parser.
// Used by the input stage, the parser core, the output stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mesp_pkg;

  // Result kinds
  typedef enum logic [3:0] {
    KIND_NOTE_OFF  = 4'd0,
    KIND_NOTE_ON   = 4'd1,
    KIND_KEY_PRESS = 4'd2,
    KIND_CTRL      = 4'd3,
    KIND_PROGRAM   = 4'd4,
    KIND_CHAN_PRES = 4'd5,
    KIND_PITCH     = 4'd6,
    KIND_SYSEX     = 4'd7,
    KIND_TEMPO     = 4'd8,
    KIND_ERROR     = 4'd9
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_TRUNCATED  = 2'd0,
    ERR_BAD_STATUS = 2'd1,
    ERR_BAD_LENGTH = 2'd2
  } err_e;

  localparam logic [7:0]  STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0]  STATUS_META   = 8'hFF;
  localparam logic [7:0]  META_TEMPO    = 8'h51;
  localparam logic [3:0]  HI_LAST_CHAN  = 4'hE;
  localparam logic [2:0]  HI_PROGRAM    = 3'h4;  // 0xCn, low 3 bits of high nibble
  localparam logic [2:0]  HI_CHAN_PRES  = 3'h5;  // 0xDn
  localparam logic [31:0] TEMPO_LEN     = 32'd3;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [31:0] tick_time;
    logic [23:0] tempo_value;
    logic [7:0]  tempo_queue;
    logic [7:0]  sysex_data;
    logic        sysex_last;
    err_e        error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== design/mesp_in_stage.sv =====
// Input register for the MIDI event stream parser.
// Depends on mesp_pkg (item_t).
`timescale 1ns / 1ps
`default_nettype none

module mesp_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [7:0]     packet_byte_i,
  input  wire logic           packet_end_i,
  input  wire logic           advance_i,    // held beat consumed by the parser
  output logic                item_valid_o,
  output mesp_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  logic            accept;
  mesp_pkg::item_t item_q;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data <= packet_byte_i;
      item_q.last <= packet_end_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== design/mesp_parser.sv =====
// Parser state and per-byte decode for the MIDI event stream parser.
// Depends on mesp_pkg (item_t, result_t, codes).
`timescale 1ns / 1ps
`default_nettype none

module mesp_parser #(
  parameter int TIME_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,      // consume item_i this cycle
  input  wire mesp_pkg::item_t item_i,
  input  wire logic [7:0]      queue_i,
  output logic                 res_valid_o,
  output mesp_pkg::result_t    res_o
);

  typedef enum logic [10:0] {
    PH_DELTA      = 11'b000_0000_0001,
    PH_DELTA_MORE = 11'b000_0000_0010,
    PH_STATUS     = 11'b000_0000_0100,
    PH_DATA1      = 11'b000_0000_1000,
    PH_DATA2      = 11'b000_0001_0000,
    PH_SYSLEN     = 11'b000_0010_0000,
    PH_SYSDATA    = 11'b000_0100_0000,
    PH_METATYPE   = 11'b000_1000_0000,
    PH_METALEN    = 11'b001_0000_0000,
    PH_TEMPO      = 11'b010_0000_0000,
    PH_SKIP       = 11'b100_0000_0000
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [TIME_BITS-8:0]   acc_q, acc_d;       // top 7 bits never feed back
  logic [TIME_BITS-1:0]   time_q, time_d;
  logic [6:0]             status_q, status_d; // bit 7 is implied
  logic [6:0]             first_q, first_d;
  logic [7:0]             meta_q, meta_d;
  logic [31:0]            len_q, len_d;
  logic [15:0]            tempo_q, tempo_d;   // two older tempo bytes
  logic                   discard_q, discard_d;

  logic [TIME_BITS-1:0]   delta_new;
  logic [TIME_BITS+31:0]  time_ext;
  logic [31:0]            tick;
  logic [31:0]            len_shift;
  logic [31:0]            len_dec;
  logic [6:0]             low7;
  logic                   more;
  logic                   err_hit;
  logic                   res_valid;
  mesp_pkg::result_t      res;

  assign low7      = item_i.data[6:0];
  assign more      = item_i.data[7];
  assign delta_new = {((phase_q == PH_DELTA_MORE) ? acc_q : '0), low7};
  assign time_ext  = {32'd0, time_q};
  assign tick      = time_ext[31:0];
  assign len_shift = {len_q[24:0], low7};
  assign len_dec   = len_q - 32'd1;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    time_d    = time_q;
    status_d  = status_q;
    first_d   = first_q;
    meta_d    = meta_q;
    len_d     = len_q;
    tempo_d   = tempo_q;
    discard_d = discard_q;
    err_hit   = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (discard_q) begin
      if (item_i.last) begin
        discard_d = 1'b0;
      end
    end else begin
      case (phase_q)
        PH_DELTA, PH_DELTA_MORE: begin
          acc_d = delta_new[TIME_BITS-8:0];
          if (more) begin
            phase_d = PH_DELTA_MORE;
          end else begin
            time_d  = time_q + delta_new;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          status_d = item_i.data[6:0];
          if (!more) begin
            err_hit    = 1'b1;
            res.error_code = mesp_pkg::ERR_BAD_STATUS;
          end else if (item_i.data[7:4] <= mesp_pkg::HI_LAST_CHAN) begin
            phase_d = PH_DATA1;
          end else if (item_i.data == mesp_pkg::STATUS_SYSEX) begin
            len_d   = '0;
            phase_d = PH_SYSLEN;
          end else if (item_i.data == mesp_pkg::STATUS_META) begin
            phase_d = PH_METATYPE;
          end else begin
            err_hit    = 1'b1;
            res.error_code = mesp_pkg::ERR_BAD_STATUS;
          end
        end
        PH_DATA1: begin
          first_d = low7;
          if (status_q[6:4] == mesp_pkg::HI_PROGRAM ||
              status_q[6:4] == mesp_pkg::HI_CHAN_PRES) begin
            res_valid      = 1'b1;
            res.kind       = mesp_pkg::kind_e'({1'b0, status_q[6:4]});
            res.channel    = status_q[3:0];
            res.first_data = low7;
            res.tick_time  = tick;
            phase_d        = PH_DELTA;
          end else begin
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          res_valid       = 1'b1;
          res.kind        = mesp_pkg::kind_e'({1'b0, status_q[6:4]});
          res.channel     = status_q[3:0];
          res.first_data  = first_q;
          res.second_data = low7;
          res.tick_time   = tick;
          phase_d         = PH_DELTA;
        end
        PH_SYSLEN: begin
          len_d = len_shift;
          if (!more) begin
            if (len_shift == '0) begin
              err_hit        = 1'b1;
              res.error_code = mesp_pkg::ERR_BAD_LENGTH;
            end else begin
              phase_d = PH_SYSDATA;
            end
          end
        end
        PH_SYSDATA: begin
          len_d          = len_dec;
          res_valid      = 1'b1;
          res.kind       = mesp_pkg::KIND_SYSEX;
          res.tick_time  = tick;
          res.sysex_data = item_i.data;
          res.sysex_last = (len_dec == '0);
          if (len_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        PH_METATYPE: begin
          meta_d  = item_i.data;
          len_d   = '0;
          phase_d = PH_METALEN;
        end
        PH_METALEN: begin
          len_d = len_shift;
          if (!more) begin
            if (meta_q == mesp_pkg::META_TEMPO) begin
              if (len_shift != mesp_pkg::TEMPO_LEN) begin
                err_hit        = 1'b1;
                res.error_code = mesp_pkg::ERR_BAD_LENGTH;
              end else begin
                tempo_d = '0;
                phase_d = PH_TEMPO;
              end
            end else if (len_shift == '0) begin
              phase_d = PH_DELTA;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_d = {tempo_q[7:0], item_i.data};
          len_d   = len_dec;
          if (len_dec == '0) begin
            res_valid       = 1'b1;
            res.kind        = mesp_pkg::KIND_TEMPO;
            res.tick_time   = tick;
            res.tempo_value = {tempo_q, item_i.data};
            res.tempo_queue = queue_i;
            phase_d         = PH_DELTA;
          end
        end
        PH_SKIP: begin
          len_d = len_dec;
          if (len_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        default: begin
          phase_d = PH_DELTA;
        end
      endcase

      if (err_hit) begin
        // error result: every other field zero, drop rest of packet
        res_valid = 1'b1;
        res.kind  = mesp_pkg::KIND_ERROR;
        phase_d   = PH_DELTA;
        discard_d = !item_i.last;
      end else if (item_i.last && phase_d != PH_DELTA) begin
        // packet ended inside an event
        res_valid = 1'b1;
        res       = '0;
        res.kind  = mesp_pkg::KIND_ERROR;
        res.error_code = mesp_pkg::ERR_TRUNCATED;
        phase_d   = PH_DELTA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DELTA;
      acc_q     <= '0;
      time_q    <= '0;
      status_q  <= '0;
      first_q   <= '0;
      meta_q    <= '0;
      len_q     <= '0;
      tempo_q   <= '0;
      discard_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      time_q    <= time_d;
      status_q  <= status_d;
      first_q   <= first_d;
      meta_q    <= meta_d;
      len_q     <= len_d;
      tempo_q   <= tempo_d;
      discard_q <= discard_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

`default_nettype wire

// ===== design/mesp_out_stage.sv =====
// Result register for the MIDI event stream parser.
// Depends on mesp_pkg (result_t).
`timescale 1ns / 1ps
`default_nettype none

module mesp_out_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,      // parser stepped this cycle
  input  wire logic               res_valid_i,
  input  wire mesp_pkg::result_t  res_i,
  input  wire logic               out_stall_i,
  output logic                    out_free_o,
  output logic                    out_valid_o,
  output mesp_pkg::result_t       res_o
);

  logic              valid_q, valid_d;
  mesp_pkg::result_t res_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/midi_event_stream_parser_core.sv =====
// Top level of the MIDI event stream parser: input register, parser, result register.
// Depends on mesp_pkg, mesp_in_stage, mesp_parser and mesp_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Parses MIDI file track events from a byte stream, one beat per byte with an
// end-of-packet mark. Each event is a variable-length delta added to a running
// tick time (TIME_BITS wide, tick_time_o shows its low 32 bits), then a status
// byte. Channel messages give one result with channel and data; each sysex
// payload byte gives one result with sysex_last on the final one; a tempo meta
// event gives one tempo result tagged with the queue number register. Other
// meta events produce nothing. A bad status byte, a bad length or a packet that
// ends inside an event gives an error result, and after an error the remainder
// of the packet is dropped. A beat is registered in the input register, decoded
// by the parser from there and its result, if any, is registered in the result
// register; the sustained rate is one beat per cycle while out_stall_i stays
// low. The only throttle is the result register: while it holds a stalled
// result the parser does not step and in_stall_o rises once the input register
// is occupied. The queue number register may be written only while the block
// is idle.
module midi_event_stream_parser_core #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  packet_byte_i,
  input  wire logic        packet_end_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       kind_o,
  output logic [3:0]       channel_o,
  output logic [6:0]       first_data_o,
  output logic [6:0]       second_data_o,
  output logic [31:0]      tick_time_o,
  output logic [23:0]      tempo_value_o,
  output logic [7:0]       tempo_queue_o,
  output logic [7:0]       sysex_data_o,
  output logic             sysex_last_o,
  output logic [1:0]       error_code_o,
  // queue number register
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic              item_valid;
  mesp_pkg::item_t   item;
  logic              out_free;
  logic              step;       // parser consumes the held beat
  logic              res_valid;
  mesp_pkg::result_t res;
  mesp_pkg::result_t res_out;
  logic [7:0]        queue_q;

  // The held beat advances whenever the result register can take whatever it yields.
  assign step = item_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_q <= '0;
    end else if (cfg_we_i) begin
      queue_q <= cfg_data_i;
    end
  end

  mesp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packet_byte_i (packet_byte_i),
    .packet_end_i  (packet_end_i),
    .advance_i     (step),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  mesp_parser #(
    .TIME_BITS (TIME_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .queue_i     (queue_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mesp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign kind_o        = res_out.kind;
  assign channel_o     = res_out.channel;
  assign first_data_o  = res_out.first_data;
  assign second_data_o = res_out.second_data;
  assign tick_time_o   = res_out.tick_time;
  assign tempo_value_o = res_out.tempo_value;
  assign tempo_queue_o = res_out.tempo_queue;
  assign sysex_data_o  = res_out.sysex_data;
  assign sysex_last_o  = res_out.sysex_last;
  assign error_code_o  = res_out.error_code;

`ifndef SYNTH
  // input backpressure only ever comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a fresh result needs a beat held in the input register the cycle before
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(item_valid))
    else $error("result appeared without a parsed beat");

  // error results carry nothing but their code
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == mesp_pkg::KIND_ERROR) |->
      (tick_time_o == '0 && channel_o == '0 && sysex_last_o == 1'b0))
    else $error("error result carries payload");
`endif

endmodule

`default_nettype wire
